@@ hdl/timed_duplicate_hash_filter_macros.svh @@
// Assertion macros for the timed duplicate hash filter.
// Used by the top level; needs nothing else.
`ifndef TIMED_DUPLICATE_HASH_FILTER_MACROS_SVH
`define TIMED_DUPLICATE_HASH_FILTER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TDHF_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tdhf check failed");

// antecedent implies consequent in the next cycle
`define TDHF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tdhf check failed");

`endif

@@ hdl/tdhf_pkg.sv @@
// Package for the timed duplicate hash filter: constants and the types
// passed along the cell chain. No dependencies.
`default_nettype none
package tdhf_pkg;
	localparam int unsigned TABLE_DEPTH_DEF = 16;
	localparam int unsigned IDX_W = 8;
	localparam logic [31:0] HASH_SEED = 32'd5381;
	localparam logic [31:0] WINDOW_RESET = 32'd25000;
	localparam int unsigned HASH_SHIFT = 5;

	typedef struct packed {
		logic tok;
		logic dup;
		logic have_free;
		logic [IDX_W-1:0] free_idx;
		logic [31:0] old_age;
		logic [IDX_W-1:0] old_idx;
	} carry_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
	} wr_t;
endpackage
`default_nettype wire

@@ hdl/tdhf_cell.sv @@
// One table entry of the duplicate filter with its stage of the search chain.
// Depends on tdhf_pkg.
`default_nettype none
module tdhf_cell #(
	parameter int IDX = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire tdhf_pkg::carry_t carry_in,
	output tdhf_pkg::carry_t carry_out,
	input wire logic [31:0] probe_hash,
	input wire logic [31:0] probe_now,
	input wire logic [31:0] window_ms,
	input wire tdhf_pkg::wr_t wr,
	input wire logic [31:0] wr_hash,
	input wire logic [31:0] wr_time
);
	logic [31:0] hash_q;
	logic [31:0] time_q;
	logic valid_q;
	logic [31:0] age;
	logic expire;
	logic live;
	logic wr_hit;
	tdhf_pkg::carry_t nxt;
	tdhf_pkg::carry_t carry_q;

	assign age = probe_now - time_q;
	assign expire = valid_q && (age > window_ms);
	assign live = valid_q && !expire;
	assign wr_hit = wr.en && (wr.idx == tdhf_pkg::IDX_W'(IDX));

	always_comb begin
		nxt = carry_in;
		if (live && (hash_q == probe_hash)) begin
			nxt.dup = 1'b1;
		end
		if (!live && !carry_in.have_free) begin
			nxt.have_free = 1'b1;
			nxt.free_idx = tdhf_pkg::IDX_W'(IDX);
		end
		if (live && (age > carry_in.old_age)) begin
			nxt.old_age = age;
			nxt.old_idx = tdhf_pkg::IDX_W'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			carry_q <= '0;
		end else begin
			carry_q <= nxt;
			if (wr_hit) begin
				valid_q <= 1'b1;
			end else if (carry_in.tok && expire) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			hash_q <= wr_hash;
			time_q <= wr_time;
		end
	end

	assign carry_out = carry_q;
endmodule
`default_nettype wire

@@ hdl/timed_duplicate_hash_filter.sv @@
// Timed duplicate hash filter: DJB2 hash of each message, checked against a
// time-windowed table. Depends on tdhf_pkg, tdhf_cell and the macros header.
//
// Usage:
//   Slave channel: one message byte per item on s_tdata, s_tlast on the final
//   byte, which also carries the current time in milliseconds.
//   Master channel: one item per message, the hash on m_tdata and the
//   duplicate and eviction flags on m_tuser.
//   cfg_wr_en/cfg_wr_data write the expiry window; write only while idle.
// Timing:
//   Non-final bytes stream back to back.
//   The final byte starts a search token that walks the chain of
//   TABLE_DEPTH cells, one cell per cycle; the outcome is then latched,
//   and a commit step updates the table and loads the output register.
//   s_tready is low from the acceptance of the final byte until that
//   commit step.
// Reset: the table is empty, the hash restarts at its seed, window 25000.
// Stall: a held result stays in the output register; further bytes are
//   taken, and a new final byte waits in the commit step until it drains.
`default_nettype none
`include "timed_duplicate_hash_filter_macros.svh"
module timed_duplicate_hash_filter #(
	parameter int TABLE_DEPTH = tdhf_pkg::TABLE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [39:0] s_tdata, // msg_byte[7:0], now_ms[39:8]
	input wire logic s_tlast,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [31:0] m_tdata, // message_hash[31:0]
	output logic [1:0] m_tuser, // is_duplicate[0], evicted_live[1]
	input wire logic cfg_wr_en,
	input wire logic [31:0] cfg_wr_data
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [31:0] window_q;
	logic [31:0] run_hash_q;
	logic [31:0] hash_q;
	logic [31:0] now_q;
	logic start_q;
	tdhf_pkg::carry_t fin_q;
	tdhf_pkg::carry_t chain [TABLE_DEPTH+1];
	tdhf_pkg::wr_t wr;
	logic [31:0] next_hash;
	logic accept;
	logic commit;
	logic out_dup_q;
	logic out_evict_q;
	logic [31:0] out_hash_q;
	logic out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign next_hash = {run_hash_q[31-tdhf_pkg::HASH_SHIFT:0], tdhf_pkg::HASH_SHIFT'(0)}
		+ run_hash_q + {24'd0, s_tdata[7:0]};
	assign commit = (state_q == ST_COMMIT) && (!out_valid_q || m_tready);

	always_comb begin
		chain[0] = '0;
		chain[0].tok = start_q;
	end

	assign wr.en = commit && !fin_q.dup;
	assign wr.idx = fin_q.have_free ? fin_q.free_idx : fin_q.old_idx;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		tdhf_cell #(
			.IDX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.carry_in(chain[g]),
			.carry_out(chain[g+1]),
			.probe_hash(hash_q),
			.probe_now(now_q),
			.window_ms(window_q),
			.wr(wr),
			.wr_hash(hash_q),
			.wr_time(now_q)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			window_q <= tdhf_pkg::WINDOW_RESET;
			run_hash_q <= tdhf_pkg::HASH_SEED;
			start_q <= 1'b0;
			out_valid_q <= 1'b0;
			fin_q <= '0;
		end else begin
			start_q <= accept && s_tlast;
			if (cfg_wr_en) begin
				window_q <= cfg_wr_data;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tlast) begin
							run_hash_q <= tdhf_pkg::HASH_SEED;
							state_q <= ST_SCAN;
						end else begin
							run_hash_q <= next_hash;
						end
					end
				end
				ST_SCAN: begin
					if (chain[TABLE_DEPTH].tok) begin
						fin_q <= chain[TABLE_DEPTH];
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			hash_q <= next_hash;
			now_q <= s_tdata[39:8];
		end
		if (commit) begin
			out_hash_q <= hash_q;
			out_dup_q <= fin_q.dup;
			out_evict_q <= !fin_q.dup && !fin_q.have_free;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_hash_q;
	assign m_tuser = {out_evict_q, out_dup_q};

	`TDHF_ASSERT_NEXT(a_start_scan, clk, arst_n, accept && s_tlast, state_q == ST_SCAN && start_q)
	`TDHF_ASSERT_NOW(a_tok_in_scan, clk, arst_n, chain[TABLE_DEPTH].tok, state_q == ST_SCAN)
	`TDHF_ASSERT_NEXT(a_commit_out, clk, arst_n, commit, m_tvalid && state_q == ST_IDLE)
	`TDHF_ASSERT_NOW(a_flags_excl, clk, arst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]))
endmodule
`default_nettype wire

@@ sim/dup_filter_monitor.sv @@
// Monitor for the timed duplicate hash filter: watches the byte, result and
// window-write channels, predicts each result and compares it field by field.
// Depends on tdhf_pkg for the hash seed, reset window and table depth.
`timescale 1ns / 100ps
module dup_filter_monitor (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [39:0] s_tdata,
	input wire logic s_tlast,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0] m_tuser,
	input wire logic cfg_wr_en,
	input wire logic [31:0] cfg_wr_data,
	output int mismatches,
	output int pending
);
	localparam int DEPTH = tdhf_pkg::TABLE_DEPTH_DEF;

	typedef struct packed {
		logic dup;
		logic [31:0] hash;
		logic evict;
	} verdict_t;

	verdict_t expected_verdicts[$];
	logic [31:0] window_ms;
	logic [31:0] running_hash;
	logic [31:0] stored_hash [0:DEPTH-1];
	logic [31:0] stored_ms [0:DEPTH-1];
	logic live [0:DEPTH-1];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	function automatic void absorb_byte(input logic [7:0] b, input logic last,
		input logic [31:0] now);
		logic [31:0] h;
		logic [31:0] age;
		logic [31:0] oldest;
		int slot;
		logic dup;
		logic evict;
		verdict_t v;
		h = (running_hash << 5) + running_hash + {24'd0, b};
		if (!last) begin
			running_hash = h;
			return;
		end
		running_hash = tdhf_pkg::HASH_SEED;
		for (int i = 0; i < DEPTH; i++) begin
			age = now - stored_ms[i];
			if (live[i] && age > window_ms)
				live[i] = 1'b0;
		end
		dup = 1'b0;
		evict = 1'b0;
		for (int i = 0; i < DEPTH; i++)
			if (live[i] && stored_hash[i] == h)
				dup = 1'b1;
		if (!dup) begin
			slot = -1;
			for (int i = 0; i < DEPTH; i++)
				if (!live[i] && slot < 0)
					slot = i;
			if (slot < 0) begin
				slot = 0;
				oldest = now - stored_ms[0];
				for (int i = 1; i < DEPTH; i++) begin
					age = now - stored_ms[i];
					if (age > oldest) begin
						oldest = age;
						slot = i;
					end
				end
				evict = 1'b1;
			end
			stored_hash[slot] = h;
			stored_ms[slot] = now;
			live[slot] = 1'b1;
		end
		v.dup = dup;
		v.hash = h;
		v.evict = evict;
		expected_verdicts.insert(expected_verdicts.size(), v);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t v;
		if (!arst_n) begin
			window_ms = tdhf_pkg::WINDOW_RESET;
			running_hash = tdhf_pkg::HASH_SEED;
			for (int i = 0; i < DEPTH; i++) begin
				live[i] = 1'b0;
				stored_hash[i] = '0;
				stored_ms[i] = '0;
			end
			expected_verdicts.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en)
				window_ms = cfg_wr_data;
			if (s_tvalid && s_tready)
				absorb_byte(s_tdata[7:0], s_tlast, s_tdata[39:8]);
			if (m_tvalid && m_tready) begin
				if (expected_verdicts.size() == 0) begin
					$error("result with no message outstanding: message_hash %h", m_tdata);
					mismatches++;
				end else begin
					v = expected_verdicts.pop_front();
					if (m_tuser[0] !== v.dup) begin
						$error("is_duplicate: expected %0d, got %0d", v.dup, m_tuser[0]);
						mismatches++;
					end
					if (m_tdata !== v.hash) begin
						$error("message_hash: expected %h, got %h", v.hash, m_tdata);
						mismatches++;
					end
					if (m_tuser[1] !== v.evict) begin
						$error("evicted_live: expected %0d, got %0d", v.evict, m_tuser[1]);
						mismatches++;
					end
				end
			end
			pending = expected_verdicts.size();
		end
	end
endmodule

@@ sim/timed_duplicate_hash_filter_tb.sv @@
// Testbench top for the timed duplicate hash filter: drives messages, window
// writes and result back-pressure; dup_filter_monitor predicts and checks.
// Depends on tdhf_pkg, dup_filter_monitor and the filter RTL.
`timescale 1ns / 100ps
module timed_duplicate_hash_filter_tb;
	localparam int RESULT_LATENCY = tdhf_pkg::TABLE_DEPTH_DEF + 2;
	localparam int SETTLE_CYCLES = 2 * RESULT_LATENCY + 4;
	localparam int PHASE_ITEMS = 250;
	localparam int POOL_SIZE = 24;
	localparam int MAX_TEXT = 16;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0; // msg_byte[7:0], now_ms[39:8]
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata; // message_hash[31:0]
	logic [1:0] m_tuser; // is_duplicate[0], evicted_live[1]
	logic cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	int mismatches;
	int pending;

	logic tx_gaps = 1'b0;
	logic rx_gaps = 1'b0;
	logic rx_hold_req = 1'b0;
	logic rx_hold_done = 1'b0;
	logic [31:0] window_now = tdhf_pkg::WINDOW_RESET;
	logic [31:0] clock_ms = '0;
	logic [7:0] pool [0:POOL_SIZE-1][0:MAX_TEXT-1];
	int pool_len [0:POOL_SIZE-1];
	logic [7:0] text [0:MAX_TEXT-1];
	int text_len = 0;
	int sent = 0;

	timed_duplicate_hash_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	dup_filter_monitor filter_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] now);
		int gap;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {now, b};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_text(input logic [31:0] now);
		for (int i = 0; i < text_len; i++)
			send_byte(text[i], i == text_len - 1, (i == text_len - 1) ? now : $urandom());
		sent += text_len;
	endtask

	// drain all results and let the block settle before writing the window
	task automatic quiesce();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input logic [31:0] value);
		quiesce();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		window_now = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [31:0] time_step();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'd0;
			4, 5, 6: return $urandom_range(1, 3);
			7: return window_now + $urandom_range(0, 2) - 32'd1;
			8: return $urandom_range(0, window_now);
			default: return $urandom();
		endcase
	endfunction

	task automatic pick_text();
		int k;
		int mode;
		mode = $urandom_range(0, 19);
		if (mode < 3) begin
			text_len = $urandom_range(1, MAX_TEXT);
			for (int i = 0; i < text_len; i++)
				text[i] = 8'($urandom());
		end else begin
			k = $urandom_range(0, POOL_SIZE - 1);
			text_len = pool_len[k];
			for (int i = 0; i < text_len; i++)
				text[i] = pool[k][i];
			if (mode < 6)
				text[$urandom_range(0, text_len - 1)] = 8'($urandom());
		end
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req && !rx_hold_done) begin
				m_tready <= 1'b0;
				rx_hold_done = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
					$urandom_range(1, 3)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		logic [31:0] windows [0:5];
		windows[0] = 32'd0;
		windows[1] = 32'd1;
		windows[2] = 32'hFFFF_FFFF;
		windows[3] = 32'd1000;
		windows[4] = tdhf_pkg::WINDOW_RESET;
		windows[5] = $urandom();
		for (int k = 0; k < POOL_SIZE; k++) begin
			pool_len[k] = $urandom_range(1, 8);
			for (int i = 0; i < MAX_TEXT; i++)
				pool[k][i] = 8'($urandom());
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window edge, expiry, wrapped time, hash overflow
		text[0] = 8'h00;
		text_len = 1;
		send_text(32'd0);
		send_text(32'd25000);
		send_text(32'd25001);
		text[0] = 8'hFF;
		send_text(32'hFFFF_FFFF);
		send_text(32'd5);
		text[0] = 8'h80;
		text[1] = 8'h7F;
		text[2] = 8'hAA;
		text[3] = 8'h55;
		text_len = 4;
		send_text(32'h7FFF_FFFF);
		for (int i = 0; i < 8; i++)
			text[i] = 8'hFF;
		text_len = 8;
		send_text(32'h8000_0000);

		for (int ph = 0; ph < 6; ph++) begin
			set_window(windows[ph]);
			tx_gaps <= (ph != 3);
			rx_gaps <= (ph != 4);
			if (ph == 2)
				rx_hold_req <= 1'b1;
			clock_ms = (ph % 2) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom();
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick_text();
				clock_ms += time_step();
				send_text(clock_ms);
			end
		end

		quiesce();
		if (mismatches == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
